@@ rtl/tmte_pkg.sv @@
// ----------------------------------------------------------------------------
// tmte_pkg: shared types and constants of the move time estimator
// Item types, profile codes and pipeline sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package tmte_pkg;

  localparam int DistW = 32;
  localparam int VelW  = 16;
  localparam int AccW  = 8;
  localparam int TimeW = 32;

  // Dividend: 100*v*v + 1000*D*a stays below 2**50.
  localparam int NumW  = 50;
  // Divisor: a*v.
  localparam int DenW  = AccW + VelW;
  // Triangular quotient stays below 2**48, so the root fits 24 bits.
  localparam int RootW = 24;

  localparam int PrepStages = 3;
  localparam int DivSteps   = NumW;
  localparam int SqrtSteps  = RootW;
  localparam int Latency    = PrepStages + DivSteps + SqrtSteps + 1;

  localparam logic [1:0] KindZero = 2'd0;
  localparam logic [1:0] KindTri  = 2'd1;
  localparam logic [1:0] KindTrap = 2'd2;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic [VelW-1:0]  velocity;
    logic [AccW-1:0]  accel_coeff;
  } cmd_t;

  typedef struct packed {
    logic [TimeW-1:0] time_ms;
    logic [1:0]       profile_kind;
    logic             saturated;
  } result_t;

  // Operands handed from the front end to the divider.
  typedef struct packed {
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
    logic [1:0]      kind;
  } prep_t;

endpackage

`default_nettype wire

@@ rtl/tmte_prep.sv @@
// ----------------------------------------------------------------------------
// tmte_prep: operand front end
// Three stages: products, profile decision and scaling, dividend select.
// ----------------------------------------------------------------------------
`default_nettype none

module tmte_prep (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  tmte_pkg::cmd_t cmd_i,
  output logic           valid_o,
  output tmte_pkg::prep_t prep_o
);
  import tmte_pkg::*;

  localparam int AdW = AccW + DistW;   // a*D
  localparam int VvW = 2 * VelW;       // v*v
  localparam int TriW = NumW + 1;      // 400000*D before truncation
  localparam int VhW = VvW + 7;        // 100*v*v

  logic s1_valid_q, s2_valid_q, s3_valid_q;

  // stage 1
  logic [DistW-1:0] d1_q;
  logic [AccW-1:0]  a1_q;
  logic [VvW-1:0]   vv1_q;
  logic [AdW-1:0]   ad1_q;
  logic [DenW-1:0]  av1_q;
  logic             zero1_q;

  // stage 2
  logic [TriW-1:0]  ptri2_q;
  logic [NumW-1:0]  pad2_q;
  logic [VhW-1:0]   pvv2_q;
  logic [AccW-1:0]  a2_q;
  logic [DenW-1:0]  av2_q;
  logic [1:0]       kind2_q;

  logic [AdW+3:0]   ad10;
  logic [1:0]       kind2_d;

  prep_t prep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d1_q    <= cmd_i.distance;
    a1_q    <= cmd_i.accel_coeff;
    vv1_q   <= VvW'(cmd_i.velocity) * VvW'(cmd_i.velocity);
    ad1_q   <= AdW'(cmd_i.accel_coeff) * AdW'(cmd_i.distance);
    av1_q   <= DenW'(cmd_i.accel_coeff) * DenW'(cmd_i.velocity);
    zero1_q <= (cmd_i.distance == '0) || (cmd_i.velocity == '0) ||
               (cmd_i.accel_coeff == '0);
  end

  // 10*a*D as shift-add
  assign ad10 = {1'b0, ad1_q, 3'b000} + {3'b000, ad1_q, 1'b0};

  always_comb begin
    if (zero1_q) begin
      kind2_d = KindZero;
    end else if (ad10 <= (AdW+4)'(vv1_q)) begin
      kind2_d = KindTri;
    end else begin
      kind2_d = KindTrap;
    end
  end

  always_ff @(posedge clk_i) begin
    ptri2_q <= TriW'(d1_q) * TriW'(400000);
    pad2_q  <= NumW'(ad1_q) * NumW'(1000);
    pvv2_q  <= VhW'(vv1_q) * VhW'(100);
    a2_q    <= a1_q;
    av2_q   <= av1_q;
    kind2_q <= kind2_d;
  end

  always_ff @(posedge clk_i) begin
    prep_q.kind <= kind2_q;
    if (kind2_q == KindTri) begin
      prep_q.num <= ptri2_q[NumW-1:0];
      prep_q.den <= DenW'(a2_q);
    end else begin
      prep_q.num <= pad2_q + NumW'(pvv2_q);
      prep_q.den <= av2_q;
    end
  end

  assign valid_o = s3_valid_q;
  assign prep_o  = prep_q;

endmodule

`default_nettype wire

@@ rtl/tmte_div.sv @@
// ----------------------------------------------------------------------------
// tmte_div: pipelined restoring divider
// One quotient bit per stage, NumW stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tmte_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  tmte_pkg::prep_t           prep_i,
  output logic                      valid_o,
  output logic [tmte_pkg::NumW-1:0] quo_o,
  output logic [1:0]                kind_o
);
  import tmte_pkg::*;

  logic            vld_q  [DivSteps];
  logic [DenW-1:0] rem_q  [DivSteps];
  logic [NumW-1:0] n_q    [DivSteps];
  logic [DenW-1:0] den_q  [DivSteps];
  logic [1:0]      kind_q [DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic            vld_in;
    logic [DenW-1:0] rem_in;
    logic [NumW-1:0] n_in;
    logic [DenW-1:0] den_in;
    logic [1:0]      kind_in;
    logic [DenW:0]   part;
    logic            ge;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign n_in    = prep_i.num;
      assign den_in  = prep_i.den;
      assign kind_in = prep_i.kind;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign n_in    = n_q[k-1];
      assign den_in  = den_q[k-1];
      assign kind_in = kind_q[k-1];
    end

    assign part = {rem_in, n_in[NumW-1]};
    assign ge   = part >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? DenW'(part - {1'b0, den_in}) : part[DenW-1:0];
      n_q[k]    <= {n_in[NumW-2:0], ge};
      den_q[k]  <= den_in;
      kind_q[k] <= kind_in;
    end
  end

  assign valid_o = vld_q[DivSteps-1];
  assign quo_o   = n_q[DivSteps-1];
  assign kind_o  = kind_q[DivSteps-1];

endmodule

`default_nettype wire

@@ rtl/tmte_sqrt.sv @@
// ----------------------------------------------------------------------------
// tmte_sqrt: pipelined integer square root
// Two radicand bits per stage; the quotient rides along for the
// trapezoidal case.
// ----------------------------------------------------------------------------
`default_nettype none

module tmte_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [tmte_pkg::NumW-1:0]  quo_i,
  input  logic [1:0]                 kind_i,
  output logic                       valid_o,
  output logic [tmte_pkg::NumW-1:0]  quo_o,
  output logic [tmte_pkg::RootW-1:0] root_o,
  output logic [1:0]                 kind_o
);
  import tmte_pkg::*;

  localparam int RemW = RootW + 2;

  logic             vld_q  [SqrtSteps];
  logic [RemW-1:0]  rem_q  [SqrtSteps];
  logic [RootW-1:0] root_q [SqrtSteps];
  logic [NumW-1:0]  quo_q  [SqrtSteps];
  logic [1:0]       kind_q [SqrtSteps];

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
    localparam int J = SqrtSteps - 1 - k;  // radicand pair handled here

    logic             vld_in;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [NumW-1:0]  quo_in;
    logic [1:0]       kind_in;
    logic [RemW+1:0]  cur;
    logic [RemW+1:0]  trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign quo_in  = quo_i;
      assign kind_in = kind_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign kind_in = kind_q[k-1];
    end

    assign cur   = {rem_in, quo_in[2*J+1 -: 2]};
    assign trial = (RemW+2)'({root_in, 2'b01});
    assign ge    = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? RemW'(cur - trial) : cur[RemW-1:0];
      root_q[k] <= {root_in[RootW-2:0], ge};
      quo_q[k]  <= quo_in;
      kind_q[k] <= kind_in;
    end
  end

  assign valid_o = vld_q[SqrtSteps-1];
  assign quo_o   = quo_q[SqrtSteps-1];
  assign root_o  = root_q[SqrtSteps-1];
  assign kind_o  = kind_q[SqrtSteps-1];

endmodule

`default_nettype wire

@@ rtl/trapezoid_move_time_estimator_core.sv @@
// ----------------------------------------------------------------------------
// trapezoid_move_time_estimator_core: move time of a trapezoidal profile
// Exact integer time estimate for one move command per clock.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd_i and pulse start_i. An item is taken at
//   every edge with start_i high; busy_o stays low, since the datapath is
//   a plain pipeline that accepts one item every cycle.
//   Result channel: done_o is high for one cycle with result_o valid.
//   There is no back-pressure; the receiver must take every item.
//   Pipeline: 3 operand stages, 50 divider stages, 24 square-root
//   stages and an output register from the accepting edge to done_o.
//   Throughput: one item per cycle; every item runs through both the
//   divider and the root pipeline, the root is used only for triangular
//   moves.
//   Reset: rst_ni clears all valid bits; items in flight are dropped.
//   No configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module trapezoid_move_time_estimator_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  tmte_pkg::cmd_t    cmd_i,
  output logic              busy_o,
  output logic              done_o,
  output tmte_pkg::result_t result_o
);
  import tmte_pkg::*;

  logic            accept;
  logic            prep_valid;
  prep_t           prep;
  logic            div_valid;
  logic [NumW-1:0] div_quo;
  logic [1:0]      div_kind;
  logic             sq_valid;
  logic [NumW-1:0]  sq_quo;
  logic [RootW-1:0] sq_root;
  logic [1:0]       sq_kind;

  logic    done_q;
  result_t res_q, res_d;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // operands: products, profile choice, dividend/divisor
  tmte_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .cmd_i   (cmd_i),
    .valid_o (prep_valid),
    .prep_o  (prep)
  );

  // quotient: 400000*D/a or (100vv+1000Da)/(av)
  tmte_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .prep_i  (prep),
    .valid_o (div_valid),
    .quo_o   (div_quo),
    .kind_o  (div_kind)
  );

  tmte_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid),
    .quo_i   (div_quo),
    .kind_i  (div_kind),
    .valid_o (sq_valid),
    .quo_o   (sq_quo),
    .root_o  (sq_root),
    .kind_o  (sq_kind)
  );

  // final pick and clamp
  always_comb begin
    res_d.time_ms      = '0;
    res_d.profile_kind = sq_kind;
    res_d.saturated    = 1'b0;
    case (sq_kind)
      KindTri: begin
        res_d.time_ms = TimeW'(sq_root);
      end
      KindTrap: begin
        if (sq_quo[NumW-1:TimeW] != '0) begin
          res_d.time_ms   = '1;
          res_d.saturated = 1'b1;
        end else begin
          res_d.time_ms = sq_quo[TimeW-1:0];
        end
      end
      default: begin
        res_d.profile_kind = KindZero;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // a result only appears a fixed latency after an accepted item
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Latency))
    else $error("result without matching command");

  a_tri_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.profile_kind == KindTri |-> !result_o.saturated)
    else $error("triangular result saturated");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.profile_kind == KindZero |->
      result_o.time_ms == '0 && !result_o.saturated)
    else $error("degenerate result not zero");

  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.saturated |-> result_o.time_ms == '1)
    else $error("saturated result not clamped");

endmodule

`default_nettype wire
